/* rtl/core/bspe_pkg.sv */
// shared types and constants for the b-spline point evaluator
`default_nettype none
package bspe_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    OP_KNOT  = 2'd0,
    OP_POINT = 2'd1,
    OP_EVAL  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CLMP = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  localparam logic [0:0] RegDegree = 1'b0;
  localparam logic [0:0] RegPoints = 1'b1;

  // command from controller to datapath
  typedef struct packed {
    logic load_u;     // capture u and clear flags
    logic knot_rd;    // issue knot read (address given separately)
    logic cmp;        // compare u against knot read data
    logic cp_rd;      // read control points into working row
    logic tl_cap;     // capture left knot
    logic tr_cap;     // capture right knot, start divide
    logic div_step;   // one divider iteration
    logic blend;      // start blend of working entry
    logic mul_step;   // blend multiplier phase
    logic clamp_chk;  // latch the last u/knot compare result as clamp flag
  } cmd_t;

  typedef struct packed {
    logic u_gt_knot;  // registered compare result
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/bspline_point_evaluator.sv */
// top level of the b-spline point evaluator
//
//  channel   dir  handshake          payload
//  s_axis    in   tvalid/tready      op, index, knot, x, y, z, u
//  m_axis    out  tvalid/tready      curve x, y, z, status
//  apb       in   psel/penable       degree (0x0), point_count (0x4)
//
// writes of knots and points are taken only when idle and no result is pending
// an evaluate runs the span search, the point fetch and the de boor steps
// before its result is valid; each step uses the 48-bit restoring divider
// the result sits in an output register; the next item waits until it is taken
// stores have no reset; reset clears only the sequencer, the config registers, the output valid and the datapath flags
`default_nettype none
module bspline_point_evaluator
  import bspe_pkg::*;
#(
  parameter int unsigned MaxPoints = 16,
  parameter int unsigned MaxKnots  = 32,
  parameter int unsigned MaxDegree = 3
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // op[1:0], entry_index[6:2], knot[38:7], x[70:39], y[102:71], z[134:103],
  // u[166:135], zero fill to 168
  input  wire logic [167:0]  s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  // curve_x[31:0], curve_y[63:32], curve_z[95:64]
  output logic [95:0]        m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]         m_axis_tuser_o,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned KIdxW = $clog2(MaxKnots);
  localparam int unsigned PIdxW = $clog2(MaxPoints);
  localparam int unsigned DegW  = $clog2(MaxDegree + 1);

  logic [1:0] degree_q;
  logic [4:0] point_count_q;
  logic       acc, start, done, busy, ovalid_q;
  op_e        op;
  cmd_t       cmd;
  sts_t       sts;
  logic [KIdxW-1:0] kaddr;
  logic [PIdxW-1:0] caddr;
  logic [DegW-1:0]  slot, bj;
  logic signed [DataW-1:0] cx, cy, cz;
  logic [1:0] cst;
  logic [95:0] odata_q;
  logic [1:0]  ouser_q;

  // config registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q      <= 2'd3;
      point_count_q <= 5'd8;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        RegDegree: degree_q      <= pwdata[1:0];
        RegPoints: point_count_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == {RegDegree, 2'b00}) prdata = 32'(degree_q);
    else if (paddr == {RegPoints, 2'b00}) prdata = 32'(point_count_q);
  end

  // accept only when idle and no result is pending
  assign s_axis_tready_o = !busy && !ovalid_q;
  assign acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign op    = op_e'(s_axis_tdata_i[1:0]);
  assign start = acc && (op == OP_EVAL);

  bspe_ctrl #(.MaxPoints(MaxPoints), .MaxKnots(MaxKnots), .MaxDegree(MaxDegree)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .degree_i(degree_q),
    .point_count_i(point_count_q), .sts_i(sts), .cmd_o(cmd),
    .knot_addr_o(kaddr), .cp_addr_o(caddr), .cp_slot_o(slot),
    .blend_j_o(bj), .busy_o(busy), .done_o(done)
  );

  bspe_dp #(.MaxPoints(MaxPoints), .MaxKnots(MaxKnots), .MaxDegree(MaxDegree)) u_dp (
    .clk_i, .rst_ni,
    .kwr_i(acc && op == OP_KNOT), .pwr_i(acc && op == OP_POINT),
    .widx_i(s_axis_tdata_i[6:2]),
    .knot_i(s_axis_tdata_i[38:7]), .px_i(s_axis_tdata_i[70:39]),
    .py_i(s_axis_tdata_i[102:71]), .pz_i(s_axis_tdata_i[134:103]),
    .u_i(s_axis_tdata_i[166:135]),
    .cmd_i(cmd), .knot_addr_i(kaddr), .cp_addr_i(caddr), .cp_slot_i(slot),
    .blend_j_i(bj), .sts_o(sts), .x_o(cx), .y_o(cy), .z_o(cz), .status_o(cst)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (done) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      ovalid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (done) begin
      odata_q <= {cz, cy, cx};
      ouser_q <= cst;
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tuser_o  = ouser_q;

endmodule
`default_nettype wire

/* rtl/core/bspe_ctrl.sv */
// sequencer for span search, point fetch and de boor levels
`default_nettype none
module bspe_ctrl
  import bspe_pkg::*;
#(
  parameter int unsigned MaxPoints = 16,
  parameter int unsigned MaxKnots  = 32,
  parameter int unsigned MaxDegree = 3,
  parameter int unsigned KIdxW     = $clog2(MaxKnots),
  parameter int unsigned PIdxW     = $clog2(MaxPoints),
  parameter int unsigned DegW      = $clog2(MaxDegree + 1),
  parameter int unsigned CntW      = $clog2(MaxPoints + MaxKnots + 2) + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [1:0]       degree_i,
  input  wire logic [4:0]       point_count_i,
  input  wire sts_t             sts_i,
  output cmd_t                  cmd_o,
  output logic [KIdxW-1:0]      knot_addr_o,
  output logic [PIdxW-1:0]      cp_addr_o,
  output logic [DegW-1:0]       cp_slot_o,
  output logic [DegW-1:0]       blend_j_o,
  output logic                  busy_o,
  output logic                  done_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SRD   = 11'b00000000010,
    S_SCMP  = 11'b00000000100,
    S_CP    = 11'b00000001000,
    S_TLRD  = 11'b00000010000,
    S_TRRD  = 11'b00000100000,
    S_DIV   = 11'b00001000000,
    S_MUL   = 11'b00010000000,
    S_NEXT  = 11'b00100000000,
    S_DONE  = 11'b01000000000,
    S_CLMP  = 11'b10000000000
  } state_e;

  localparam int unsigned DivSteps = 48;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  state_e state_q, state_d;
  logic [DegW-1:0]  deg_q, deg_d;
  logic [CntW-1:0]  maxdec_q, maxdec_d, dec_q, dec_d;
  logic [DegW-1:0]  m_q, m_d;       // point copy index
  logic [DegW-1:0]  lvl_q, lvl_d;   // current level
  logic [DegW-1:0]  j_q, j_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;
  logic [1:0]       ph_q, ph_d;

  logic [CntW-1:0] deg_w, pc_w, kidx, kaddr;

  always_comb begin
    deg_w = CntW'(degree_i);
    if (deg_w > CntW'(MaxDegree))  deg_w = CntW'(MaxDegree);
    if (deg_w > CntW'(MaxPoints - 1)) deg_w = CntW'(MaxPoints - 1);
    pc_w = CntW'(point_count_i);
    if (pc_w > CntW'(MaxPoints)) pc_w = CntW'(MaxPoints);
    if (pc_w < deg_w + CntW'(1)) pc_w = deg_w + CntW'(1);
  end

  always_comb begin
    state_d  = state_q;
    deg_d    = deg_q;
    maxdec_d = maxdec_q;
    dec_d    = dec_q;
    m_d      = m_q;
    lvl_d    = lvl_q;
    j_d      = j_q;
    dcnt_d   = dcnt_q;
    ph_d     = ph_q;
    cmd_o    = '0;
    kidx     = '0;
    done_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_u = 1'b1;
          deg_d    = DegW'(deg_w);
          maxdec_d = pc_w - deg_w - CntW'(1);
          dec_d    = '0;
          state_d  = S_SRD;
        end
      end
      S_SRD: begin
        kidx = CntW'(deg_q) + CntW'(1) + dec_q;
        cmd_o.knot_rd = 1'b1;
        state_d = S_SCMP;
      end
      S_SCMP: begin
        cmd_o.cmp = 1'b1;
        state_d = S_CLMP;
      end
      S_CLMP: begin
        if (sts_i.u_gt_knot && dec_q < maxdec_q) begin
          dec_d = dec_q + CntW'(1);
          state_d = S_SRD;
        end else begin
          cmd_o.clamp_chk = (dec_q == maxdec_q);
          m_d = '0;
          state_d = S_CP;
        end
      end
      S_CP: begin
        cmd_o.cp_rd = 1'b1;
        if (m_q == deg_q) begin
          lvl_d = '0;
          j_d   = '0;
          state_d = (deg_q == '0) ? S_DONE : S_TLRD;
        end else begin
          m_d = m_q + DegW'(1);
        end
      end
      S_TLRD: begin
        // left knot base+1+j, base = dec + lvl
        kidx = dec_q + CntW'(lvl_q) + CntW'(1) + CntW'(j_q);
        cmd_o.knot_rd = 1'b1;
        ph_d = 2'd0;
        state_d = S_TRRD;
      end
      S_TRRD: begin
        // right knot base+k+j, k = deg+1-lvl
        kidx = dec_q + CntW'(deg_q) + CntW'(1) + CntW'(j_q);
        if (ph_q == 2'd0) begin
          cmd_o.tl_cap  = 1'b1;
          cmd_o.knot_rd = 1'b1;
          ph_d = 2'd1;
        end else begin
          cmd_o.tr_cap = 1'b1;
          dcnt_d = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (dcnt_q == DivCntW'(DivSteps - 1)) begin
          ph_d = 2'd0;
          state_d = S_MUL;
        end else begin
          dcnt_d = dcnt_q + DivCntW'(1);
        end
      end
      S_MUL: begin
        if (ph_q == 2'd0) begin
          cmd_o.blend = 1'b1;
          ph_d = 2'd1;
        end else if (ph_q == 2'd1) begin
          cmd_o.mul_step = 1'b1;
          ph_d = 2'd2;
        end else begin
          cmd_o.mul_step = 1'b1;
          ph_d = 2'd0;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (j_q + DegW'(1) + lvl_q >= deg_q) begin
          j_d = '0;
          if (lvl_q + DegW'(1) == deg_q) begin
            state_d = S_DONE;
          end else begin
            lvl_d = lvl_q + DegW'(1);
            state_d = S_TLRD;
          end
        end else begin
          j_d = j_q + DegW'(1);
          state_d = S_TLRD;
        end
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    kaddr = kidx;
    if (kidx >= CntW'(MaxKnots)) kaddr = CntW'(MaxKnots - 1);
  end
  assign knot_addr_o = kaddr[KIdxW-1:0];
  assign cp_addr_o   = PIdxW'(dec_q + CntW'(m_q));
  assign cp_slot_o   = m_q;
  assign blend_j_o   = j_q;
  assign busy_o      = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      deg_q    <= '0;
      maxdec_q <= '0;
      dec_q    <= '0;
      m_q      <= '0;
      lvl_q    <= '0;
      j_q      <= '0;
      dcnt_q   <= '0;
      ph_q     <= '0;
    end else begin
      state_q  <= state_d;
      deg_q    <= deg_d;
      maxdec_q <= maxdec_d;
      dec_q    <= dec_d;
      m_q      <= m_d;
      lvl_q    <= lvl_d;
      j_q      <= j_d;
      dcnt_q   <= dcnt_d;
      ph_q     <= ph_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bspe_dp.sv */
// stores, restoring divider and blend multiplier for de boor steps
`default_nettype none
module bspe_dp
  import bspe_pkg::*;
#(
  parameter int unsigned MaxPoints = 16,
  parameter int unsigned MaxKnots  = 32,
  parameter int unsigned MaxDegree = 3,
  parameter int unsigned KIdxW     = $clog2(MaxKnots),
  parameter int unsigned PIdxW     = $clog2(MaxPoints),
  parameter int unsigned DegW      = $clog2(MaxDegree + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    kwr_i,
  input  wire logic                    pwr_i,
  input  wire logic [4:0]              widx_i,
  input  wire logic signed [DataW-1:0] knot_i,
  input  wire logic signed [DataW-1:0] px_i,
  input  wire logic signed [DataW-1:0] py_i,
  input  wire logic signed [DataW-1:0] pz_i,
  input  wire logic signed [DataW-1:0] u_i,
  input  wire cmd_t                    cmd_i,
  input  wire logic [KIdxW-1:0]        knot_addr_i,
  input  wire logic [PIdxW-1:0]        cp_addr_i,
  input  wire logic [DegW-1:0]         cp_slot_i,
  input  wire logic [DegW-1:0]         blend_j_i,
  output sts_t                         sts_o,
  output logic signed [DataW-1:0]      x_o,
  output logic signed [DataW-1:0]      y_o,
  output logic signed [DataW-1:0]      z_o,
  output logic [1:0]                   status_o
);

  localparam int unsigned DivW = 48;   // |u-tl|<<16 fits in 49 bits incl sign
  localparam logic signed [33:0] ALim = 34'sd16777216;

  logic signed [DataW-1:0] knot_mem [MaxKnots];
  logic signed [DataW-1:0] cx_mem [MaxPoints];
  logic signed [DataW-1:0] cy_mem [MaxPoints];
  logic signed [DataW-1:0] cz_mem [MaxPoints];
  logic signed [DataW-1:0] krd_q;
  logic signed [DataW-1:0] u_q;
  logic signed [DataW-1:0] wx_q [MaxDegree+1];
  logic signed [DataW-1:0] wy_q [MaxDegree+1];
  logic signed [DataW-1:0] wz_q [MaxDegree+1];
  logic signed [DataW-1:0] tl_q;
  logic                    cmpr_q, clamp_q, zero_q, skip_q, neg_q;
  logic [DivW-1:0]         num_q, quo_q;
  logic [DivW:0]           rem_q;
  logic [32:0]             den_q;
  logic [DivW:0]           rem_sh;
  logic signed [33:0]      alpha;
  logic signed [49:0]      qs;
  logic signed [32:0]      dx_q, dy_q, dz_q;
  logic signed [33:0]      alpha_q;
  logic signed [66:0]      px_q, py_q, pz_q;
  logic                    mph_q;

  function automatic logic signed [DataW-1:0] fin(
    input logic signed [DataW-1:0] p0, input logic signed [66:0] prod);
    logic signed [66:0] q, s;
    begin
      q = prod >>> 16;
      if (prod < 0 && prod[15:0] != 16'd0) q = q + 67'sd1;
      s = 67'(p0) + q;
      if (s > 67'sd2147483647) fin = 32'sh7fffffff;
      else if (s < -67'sd2147483648) fin = 32'sh80000000;
      else fin = s[DataW-1:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (kwr_i && 32'(widx_i) < MaxKnots) knot_mem[KIdxW'(widx_i)] <= knot_i;
    if (pwr_i && 32'(widx_i) < MaxPoints) begin
      cx_mem[PIdxW'(widx_i)] <= px_i;
      cy_mem[PIdxW'(widx_i)] <= py_i;
      cz_mem[PIdxW'(widx_i)] <= pz_i;
    end
    if (cmd_i.knot_rd) krd_q <= knot_mem[knot_addr_i];
  end

  assign rem_sh = {rem_q[DivW-1:0], num_q[DivW-1]};

  always_comb begin
    qs = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    if (qs > 50'(ALim)) alpha = ALim;
    else if (qs < -50'(ALim)) alpha = -ALim;
    else alpha = qs[33:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmpr_q  <= 1'b0;
      clamp_q <= 1'b0;
      zero_q  <= 1'b0;
      skip_q  <= 1'b0;
      mph_q   <= 1'b0;
    end else begin
      if (cmd_i.load_u) begin
        clamp_q <= 1'b0;
        zero_q  <= 1'b0;
      end
      if (cmd_i.cmp) cmpr_q <= (u_q > krd_q);
      if (cmd_i.clamp_chk) clamp_q <= cmpr_q;
      if (cmd_i.tr_cap) begin
        skip_q <= (krd_q == tl_q);
        if (krd_q == tl_q) zero_q <= 1'b1;
      end
      if (cmd_i.blend) mph_q <= 1'b0;
      else if (cmd_i.mul_step) mph_q <= ~mph_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [32:0] d, n;
    logic [32:0] da, na;
    if (cmd_i.load_u) u_q <= u_i;
    if (cmd_i.tl_cap) tl_q <= krd_q;
    if (cmd_i.tr_cap) begin
      d  = 33'(krd_q) - 33'(tl_q);
      n  = 33'(u_q) - 33'(tl_q);
      da = d[32] ? 33'(-d) : 33'(d);
      na = n[32] ? 33'(-n) : 33'(n);
      den_q <= da;
      num_q <= {na[31:0], 16'd0};
      neg_q <= d[32] ^ n[32];
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[DivW-2:0], 1'b0};
      if (rem_sh >= (DivW+1)'(den_q)) begin
        rem_q <= rem_sh - (DivW+1)'(den_q);
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
    // working row: point copy, then blends in place
    if (cmd_i.cp_rd) begin
      wx_q[cp_slot_i] <= cx_mem[cp_addr_i];
      wy_q[cp_slot_i] <= cy_mem[cp_addr_i];
      wz_q[cp_slot_i] <= cz_mem[cp_addr_i];
    end
    if (cmd_i.blend) begin
      alpha_q <= alpha;
      dx_q <= 33'(wx_q[blend_j_i + DegW'(1)]) - 33'(wx_q[blend_j_i]);
      dy_q <= 33'(wy_q[blend_j_i + DegW'(1)]) - 33'(wy_q[blend_j_i]);
      dz_q <= 33'(wz_q[blend_j_i + DegW'(1)]) - 33'(wz_q[blend_j_i]);
    end else if (cmd_i.mul_step && !mph_q) begin
      px_q <= 67'(alpha_q) * 67'(dx_q);
      py_q <= 67'(alpha_q) * 67'(dy_q);
      pz_q <= 67'(alpha_q) * 67'(dz_q);
    end else if (cmd_i.mul_step && mph_q && !skip_q) begin
      wx_q[blend_j_i] <= fin(wx_q[blend_j_i], px_q);
      wy_q[blend_j_i] <= fin(wy_q[blend_j_i], py_q);
      wz_q[blend_j_i] <= fin(wz_q[blend_j_i], pz_q);
    end
  end

  assign sts_o.u_gt_knot = cmpr_q;
  assign x_o = wx_q[0];
  assign y_o = wy_q[0];
  assign z_o = wz_q[0];
  assign status_o = zero_q ? ST_ZERO : (clamp_q ? ST_CLMP : ST_OK);

endmodule
`default_nettype wire
